// ===== rtl/lfu_pkg.sv =====
// shared types and constants for the lfu/lru page replacement block
// no dependencies; imported by lfu_table and lfu_lru_page_replacement
`timescale 1ns / 1ps
`default_nettype none

package lfu_pkg;

   localparam int MAX_FRAMES = 16;
   localparam int SLOT_W     = $clog2(MAX_FRAMES);
   localparam int FILL_W     = $clog2(MAX_FRAMES + 1);
   localparam int PAGE_W     = 20;
   localparam int CNT_W      = 32;
   localparam int CSR_W      = 5;

   localparam logic [CSR_W-1:0] FRAMES_RESET = CSR_W'(16);

   typedef struct packed {
      logic              valid;
      logic [PAGE_W-1:0] page;
      logic [CNT_W-1:0]  count;
      logic [CNT_W-1:0]  stamp;
   } lfu_entry_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      logic [PAGE_W-1:0] page;
      logic [CNT_W-1:0]  count;
      logic [CNT_W-1:0]  stamp;
   } lfu_write_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == '1) ? v : v + CNT_W'(1);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/lfu_table.sv =====
// resident page table: page, use count and last-use stamp per slot, plus valid bits
// one write port and one registered read port; uses lfu_pkg
`timescale 1ns / 1ps
`default_nettype none

module lfu_table import lfu_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [SLOT_W-1:0] rd_addr,
   output lfu_entry_type      rd_data,
   input  wire lfu_write_type wr
);

   logic [PAGE_W-1:0]     page_mem  [MAX_FRAMES];
   logic [CNT_W-1:0]      count_mem [MAX_FRAMES];
   logic [CNT_W-1:0]      stamp_mem [MAX_FRAMES];
   logic [MAX_FRAMES-1:0] valid_ff;
   logic                  rd_valid_ff;
   logic [PAGE_W-1:0]     rd_page_ff;
   logic [CNT_W-1:0]      rd_count_ff;
   logic [CNT_W-1:0]      rd_stamp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         page_mem[wr.addr]  <= wr.page;
         count_mem[wr.addr] <= wr.count;
         stamp_mem[wr.addr] <= wr.stamp;
      end
      rd_page_ff  <= page_mem[rd_addr];
      rd_count_ff <= count_mem[rd_addr];
      rd_stamp_ff <= stamp_mem[rd_addr];
   end

   always_comb begin
      rd_data.valid = rd_valid_ff;
      rd_data.page  = rd_page_ff;
      rd_data.count = rd_count_ff;
      rd_data.stamp = rd_stamp_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/lfu_lru_page_replacement.sv =====
// top level: lfu page replacement with lru tie-break, scan sequencer and counters
// depends on lfu_pkg and lfu_table
`timescale 1ns / 1ps
`default_nettype none

// usage
// - a request is taken on a rising edge with start high and busy low; its page
//   number is on req_page_number
// - the block then walks all MAX_FRAMES table slots, one slot per cycle through
//   the table's single registered read port and one shared key comparator,
//   looking for a hit and tracking the lowest {use count, last-use stamp}
// - the update state then writes the table and the counters; rsp_valid is then high
//   for exactly one cycle with hit, slot, evicted page and running totals
// - busy falls in the same cycle that rsp_valid rises, so the next request is
//   taken at the edge that ends that cycle; no new request is taken while
//   one is still in progress
// - the receiver cannot stall; each response must be captured in its cycle
// - csr_we writes the frame limit (reset 16) and is meant for idle periods only
// - reset (synchronous) clears valid bits, counters, the reference number and
//   the fill count; no clearing pass is needed

module lfu_lru_page_replacement import lfu_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [PAGE_W-1:0] req_page_number,
   input  wire logic              csr_we,
   input  wire logic [CSR_W-1:0]  csr_wdata,
   output logic                   rsp_valid,
   output logic                   rsp_hit,
   output logic [SLOT_W-1:0]      rsp_slot,
   output logic                   rsp_evicted_valid,
   output logic [PAGE_W-1:0]      rsp_evicted_page,
   output logic [CNT_W-1:0]       rsp_hit_total,
   output logic [CNT_W-1:0]       rsp_miss_total
);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPDATE} state_type;

   state_type         state_ff, state_in;
   logic [FILL_W-1:0] idx_ff, idx_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic              found_ff, found_in;
   logic [SLOT_W-1:0] found_slot_ff, found_slot_in;
   logic [CNT_W-1:0]  found_cnt_ff, found_cnt_in;
   logic              have_ff, have_in;
   logic [SLOT_W-1:0] best_slot_ff, best_slot_in;
   logic [CNT_W-1:0]  best_cnt_ff, best_cnt_in;
   logic [CNT_W-1:0]  best_time_ff, best_time_in;
   logic [PAGE_W-1:0] best_page_ff, best_page_in;
   logic [CNT_W-1:0]  ref_ff, ref_in;
   logic [FILL_W-1:0] filled_ff, filled_in;
   logic [CNT_W-1:0]  hit_ff, hit_in;
   logic [CNT_W-1:0]  miss_ff, miss_in;
   logic [CSR_W-1:0]  frames_ff, frames_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic              rsp_ev_ff, rsp_ev_in;
   logic [PAGE_W-1:0] rsp_ev_page_ff, rsp_ev_page_in;

   lfu_entry_type     rd;
   lfu_write_type     wr;
   logic [SLOT_W-1:0] eval_slot;
   logic              key_lt;
   logic [FILL_W-1:0] limit;

   lfu_table u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (idx_ff[SLOT_W-1:0]),
      .rd_data (rd),
      .wr      (wr)
   );

   // a limit of zero acts as one, above the table size acts as the table size
   always_comb begin
      if (frames_ff == '0) begin
         limit = FILL_W'(1);
      end else if (32'(frames_ff) > 32'(MAX_FRAMES)) begin
         limit = FILL_W'(MAX_FRAMES);
      end else begin
         limit = FILL_W'(frames_ff);
      end
   end

   // read data is registered, so it belongs to the address of the previous cycle
   assign eval_slot = SLOT_W'(idx_ff - FILL_W'(1));
   // shared comparator: lower count first, then older stamp
   assign key_lt    = {rd.count, rd.stamp} < {best_cnt_ff, best_time_ff};

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      page_in        = page_ff;
      found_in       = found_ff;
      found_slot_in  = found_slot_ff;
      found_cnt_in   = found_cnt_ff;
      have_in        = have_ff;
      best_slot_in   = best_slot_ff;
      best_cnt_in    = best_cnt_ff;
      best_time_in   = best_time_ff;
      best_page_in   = best_page_ff;
      ref_in         = ref_ff;
      filled_in      = filled_ff;
      hit_in         = hit_ff;
      miss_in        = miss_ff;
      frames_in      = csr_we ? csr_wdata : frames_ff;
      rsp_valid_in   = 1'b0;
      rsp_hit_in     = rsp_hit_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_ev_in      = rsp_ev_ff;
      rsp_ev_page_in = rsp_ev_page_ff;
      wr.en          = 1'b0;
      wr.addr        = '0;
      wr.page        = page_ff;
      wr.count       = '0;
      wr.stamp       = ref_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               page_in      = req_page_number;
               idx_in       = '0;
               found_in     = 1'b0;
               have_in      = 1'b0;
               best_slot_in = '0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + FILL_W'(1);
            if (idx_ff != '0) begin
               if (rd.valid && !found_ff && rd.page == page_ff) begin
                  found_in      = 1'b1;
                  found_slot_in = eval_slot;
                  found_cnt_in  = rd.count;
               end
               if (rd.valid && (!have_ff || key_lt)) begin
                  have_in      = 1'b1;
                  best_slot_in = eval_slot;
                  best_cnt_in  = rd.count;
                  best_time_in = rd.stamp;
                  best_page_in = rd.page;
               end
            end
            if (idx_ff == FILL_W'(MAX_FRAMES)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            wr.en        = 1'b1;
            ref_in       = sat_inc(ref_ff);
            rsp_valid_in = 1'b1;
            rsp_hit_in   = found_ff;
            rsp_ev_in    = 1'b0;
            rsp_ev_page_in = '0;
            if (found_ff) begin
               wr.addr  = found_slot_ff;
               wr.count = sat_inc(found_cnt_ff);
               hit_in   = sat_inc(hit_ff);
            end else begin
               miss_in = sat_inc(miss_ff);
               if (filled_ff < limit) begin
                  wr.addr   = filled_ff[SLOT_W-1:0];
                  filled_in = filled_ff + FILL_W'(1);
               end else begin
                  wr.addr        = best_slot_ff;
                  rsp_ev_in      = have_ff;
                  rsp_ev_page_in = have_ff ? best_page_ff : '0;
               end
            end
            rsp_slot_in = wr.addr;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         have_ff      <= 1'b0;
         ref_ff       <= '0;
         filled_ff    <= '0;
         hit_ff       <= '0;
         miss_ff      <= '0;
         frames_ff    <= FRAMES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         found_ff     <= found_in;
         have_ff      <= have_in;
         ref_ff       <= ref_in;
         filled_ff    <= filled_in;
         hit_ff       <= hit_in;
         miss_ff      <= miss_in;
         frames_ff    <= frames_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      page_ff        <= page_in;
      found_slot_ff  <= found_slot_in;
      found_cnt_ff   <= found_cnt_in;
      best_slot_ff   <= best_slot_in;
      best_cnt_ff    <= best_cnt_in;
      best_time_ff   <= best_time_in;
      best_page_ff   <= best_page_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_ev_ff      <= rsp_ev_in;
      rsp_ev_page_ff <= rsp_ev_page_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_evicted_valid = rsp_ev_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_hit_total     = hit_ff;
   assign rsp_miss_total    = miss_ff;

   a_rsp_after_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_UPDATE))
      else $error("response without update cycle");

   a_evict_only_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_evicted_valid) |-> !rsp_hit)
      else $error("eviction reported on a hit");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(filled_ff) <= 32'(MAX_FRAMES))
      else $error("fill count beyond table size");

   a_busy_drop_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("busy dropped without a response");

   a_scan_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (32'(idx_ff) <= 32'(MAX_FRAMES)))
      else $error("scan index overrun");

endmodule

`default_nettype wire
